// ----- hdl/dsf_pkg.sv -----
package dsf_pkg;

  // field widths
  localparam int IntWidth   = 24;
  localparam int FracWidth  = 30;
  localparam int ZeroWidth  = 4;
  localparam int TotalWidth = 5;
  localparam int ExpWidth   = 8;
  localparam int MantFrac   = 23;

  // significant bits formed before rounding: leading one, mantissa, round bit
  localparam int MantBits = 25;

  localparam int MaxFracDigits = 9;
  localparam int ExpBias       = 127;
  // exponent before the first shift: the leading one of the integer part
  // needs 25 - len shifts to reach the top cell
  localparam int ExpStart      = ExpBias + IntWidth;

  typedef enum logic [1:0] {
    StIdle,
    StPrep,
    StRun,
    StRound
  } dsf_state_e;

  // per-cycle control shared by every mantissa cell
  typedef struct packed {
    logic load;
    logic shift;
  } dsf_cell_ctrl_t;

  // powers of ten up to the largest denominator
  function automatic logic [FracWidth-1:0] pow10(input logic [3:0] n);
    logic [FracWidth-1:0] p;
    case (n)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      4'd9:    p = 30'd1000000000;
      default: p = 30'd1;
    endcase
    return p;
  endfunction

  // number of decimal digits of a value, zero for zero
  function automatic logic [3:0] dec_digits(input logic [FracWidth-1:0] v);
    logic [3:0] d;
    d = '0;
    for (int i = 0; i < 10; i++) begin
      if (v >= pow10(4'(i))) begin
        d = 4'(i + 1);
      end
    end
    return d;
  endfunction

endpackage

// ----- hdl/decimal_to_single_float.sv -----
// Decimal to single-precision converter.
// A transaction is accepted at a rising edge with start high and busy low;
// it carries the integer part, the fraction digits read as an integer, the
// count of zeros after the point, a fraction flag and the sign.
// The result appears on float_bits_o and range_error_o with done_o high for
// exactly one cycle; the receiver cannot stall and must take it then.
// From the accepting edge to the done_o cycle the block passes a set-up
// step (digit count and power-of-ten lookup), one mantissa shift per
// binary place, a step that sees the top cell set and a rounding step.
// The shift count is 25 - bit length of the integer part, plus the
// leading zero binary places of a pure fraction (up to 29 more); range
// errors and zero values finish after the set-up step. The row of 25
// mantissa cells is fed one binary place per cycle by the doubling and
// compare step.
// busy stays high from acceptance until the result cycle; a new transaction
// may be accepted in the cycle in which done_o is high.
// Reset (rst_ni low, asynchronous) returns the block to idle with no result.
module decimal_to_single_float
  import dsf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [IntWidth-1:0]  int_part_i,
  input  logic [FracWidth-1:0] frac_value_i,
  input  logic [ZeroWidth-1:0] frac_zeros_i,
  input  logic                 has_fraction_i,
  input  logic                 negative_i,
  output logic                 done_o,
  output logic [31:0]          float_bits_o,
  output logic                 range_error_o
);

  dsf_state_e state_q, state_d;

  logic [IntWidth-1:0]  ip_q;
  logic [FracWidth-1:0] fv_q;
  logic [ZeroWidth-1:0] fz_q;
  logic                 hasf_q;
  logic                 neg_q;

  logic [FracWidth-1:0] rem_q, rem_d;
  logic [FracWidth-1:0] den_q, den_d;
  logic [ExpWidth-1:0]  exp_q, exp_d;

  logic                 done_q, done_d;
  logic [31:0]          float_q, float_d;
  logic                 err_q, err_d;

  dsf_cell_ctrl_t       cell_ctrl;
  logic [MantBits-1:0]  mant;

  logic                 frac_on;
  logic [TotalWidth-1:0] total;
  logic [FracWidth:0]   rem2;
  logic                 new_bit;
  logic [MantBits:0]    rnd;
  logic [MantBits-1:0]  rsh;

  // capture the transaction
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      ip_q   <= int_part_i;
      fv_q   <= frac_value_i;
      fz_q   <= frac_zeros_i;
      hasf_q <= has_fraction_i;
      neg_q  <= negative_i;
    end
  end

  // mantissa row
  for (genvar k = 0; k < MantBits; k++) begin : g_cell
    logic load_bit;
    logic shift_bit;
    if (k < IntWidth) begin : g_ld
      assign load_bit = ip_q[k];
    end else begin : g_ld0
      assign load_bit = 1'b0;
    end
    if (k == 0) begin : g_first
      assign shift_bit = new_bit;
    end else begin : g_next
      assign shift_bit = mant[k-1];
    end
    dsf_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl),
      .load_bit_i  (load_bit),
      .shift_bit_i (shift_bit),
      .bit_o       (mant[k])
    );
  end

  // fraction set-up and the doubling step
  assign frac_on = hasf_q && (fv_q != '0);
  assign total   = {1'b0, dec_digits(fv_q)} + TotalWidth'(fz_q);
  assign rem2    = {rem_q, 1'b0};
  assign new_bit = (rem2 >= {1'b0, den_q});

  // rounding: add one at the round bit and drop it
  assign rnd = {1'b0, mant} + (MantBits+1)'(1);
  assign rsh = rnd[MantBits:1];

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    den_q   <= den_d;
    exp_q   <= exp_d;
    float_q <= float_d;
    err_q   <= err_d;
  end

  // next state and controls
  always_comb begin
    state_d   = state_q;
    rem_d     = rem_q;
    den_d     = den_q;
    exp_d     = exp_q;
    float_d   = float_q;
    err_d     = err_q;
    done_d    = 1'b0;
    cell_ctrl = '0;
    case (state_q)
      StIdle: begin
        if (start) begin
          state_d = StPrep;
        end
      end
      StPrep: begin
        if (frac_on && (total > TotalWidth'(MaxFracDigits))) begin
          float_d = '0;
          err_d   = 1'b1;
          done_d  = 1'b1;
          state_d = StIdle;
        end else if (!frac_on && (ip_q == '0)) begin
          float_d = {neg_q, 31'd0};
          err_d   = 1'b0;
          done_d  = 1'b1;
          state_d = StIdle;
        end else begin
          cell_ctrl.load = 1'b1;
          rem_d   = frac_on ? fv_q : '0;
          den_d   = frac_on ? pow10(total[3:0]) : FracWidth'(1);
          exp_d   = ExpWidth'(ExpStart);
          state_d = StRun;
        end
      end
      StRun: begin
        if (mant[MantBits-1]) begin
          state_d = StRound;
        end else begin
          cell_ctrl.shift = 1'b1;
          rem_d = new_bit ? FracWidth'(rem2 - {1'b0, den_q}) : rem2[FracWidth-1:0];
          exp_d = exp_q - ExpWidth'(1);
        end
      end
      StRound: begin
        if (rsh[MantBits-1]) begin
          float_d = {neg_q, exp_q + ExpWidth'(1), rsh[MantFrac:1]};
        end else begin
          float_d = {neg_q, exp_q, rsh[MantFrac-1:0]};
        end
        err_d   = 1'b0;
        done_d  = 1'b1;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign busy          = (state_q != StIdle);
  assign done_o        = done_q;
  assign float_bits_o  = float_q;
  assign range_error_o = err_q;

endmodule

// ----- hdl/dsf_cell.sv -----
module dsf_cell
  import dsf_pkg::*;
(
  input  logic           clk_i,
  input  dsf_cell_ctrl_t ctrl_i,
  input  logic           load_bit_i,
  input  logic           shift_bit_i,
  output logic           bit_o
);

  logic bit_q;

  // one mantissa bit: parallel load, or take the neighbour's bit
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      bit_q <= load_bit_i;
    end else if (ctrl_i.shift) begin
      bit_q <= shift_bit_i;
    end
  end

  assign bit_o = bit_q;

endmodule
